// ===== rtl/idfl_pkg.sv =====
package idfl_pkg;

   // Size of the ID space and the widths that follow from it.
   localparam int unsigned MAX_IDS = 256;
   localparam int unsigned ID_W    = 8;   // bits of one ID
   localparam int unsigned CNT_W   = 9;   // holds 0 .. MAX_IDS

   localparam logic [CNT_W-1:0] POOL_RESET = CNT_W'(MAX_IDS);
   localparam logic [CNT_W-1:0] POOL_MIN   = CNT_W'(1);
   localparam logic [CNT_W-1:0] POOL_MAX   = CNT_W'(MAX_IDS);

   // Command codes; code 3 means nothing and is served by a default arm.
   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_CHECK   = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

endpackage

// ===== rtl/idfl_ram.sv =====
module idfl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/id_free_list_allocator.sv =====
// Channel   Dir  Handshake              Payload
// req_      in   req_valid / req_stall  req_cmd[1:0], req_number[7:0]
// rsp_      out  rsp_valid / rsp_stall  rsp_granted, rsp_number_out[7:0],
//                                       rsp_available, rsp_released
// csr_      in   csr_valid / csr_ready  csr_pool_size[8:0]
//
// One beat per cycle sustained while rsp is not stalled; a command moves from
// req to rsp through the input and result registers. The single pass from the
// input register through the used map, stack top and fresh counter sets that
// rate. Reset clears the used map flops, stack count and fresh counter at once;
// no clearing pass. A stalled rsp beat holds the input register, which then
// stalls req. csr writes are taken only while the input register is empty.
module id_free_list_allocator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_number,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_granted,
   output logic [7:0] rsp_number_out,
   output logic       rsp_available,
   output logic       rsp_released,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_pool_size
);

   localparam int unsigned ID_W  = idfl_pkg::ID_W;
   localparam int unsigned CNT_W = idfl_pkg::CNT_W;

   // Input register
   logic            in_valid_ff, in_valid_in;
   logic [1:0]      in_cmd_ff;
   logic [ID_W-1:0] in_num_ff;

   // Result register
   logic            out_valid_ff, out_valid_in;
   logic            out_granted_ff, out_granted_in;
   logic [ID_W-1:0] out_number_ff, out_number_in;
   logic            out_available_ff, out_available_in;
   logic            out_released_ff, out_released_in;

   // Allocator state
   logic [CNT_W-1:0]           pool_ff, pool_in;
   logic [idfl_pkg::MAX_IDS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [CNT_W-1:0]           fresh_ff, fresh_in;
   logic [ID_W-1:0]            top_ff, top_in;     // stack entry at cnt-1
   logic                       byp_valid_ff, byp_valid_in;
   logic [ID_W-1:0]            byp_data_ff, byp_data_in;

   logic            accept;
   logic            advance;
   logic            csr_fire;
   logic            in_range;
   logic [CNT_W-1:0] cnt_dec;
   logic [CNT_W-1:0] rd_full;
   logic            wr_en;
   logic [ID_W-1:0] wr_addr;
   logic [ID_W-1:0] rd_addr;
   logic [ID_W-1:0] ram_rd_data;
   logic [ID_W-1:0] second;        // stack entry at cnt-2
   logic [ID_W-1:0] alloc_id;
   logic            alloc_ok;
   logic            release_ok;

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !in_valid_ff;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Release stack: top entry lives in top_ff, the rest in the RAM. The RAM
   // is always reading the entry below the top for the next cycle; a push
   // writes that very entry, so carry it over in the bypass register.
   // ---------------------------------------------------------------------
   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign wr_addr = cnt_dec[ID_W-1:0];
   assign rd_full = cnt_in - CNT_W'(2);
   assign rd_addr = rd_full[ID_W-1:0];
   assign second  = byp_valid_ff ? byp_data_ff : ram_rd_data;

   idfl_ram #(
      .WIDTH (ID_W),
      .DEPTH (idfl_pkg::MAX_IDS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Command decode and state update
   // ---------------------------------------------------------------------
   assign in_range   = {1'b0, in_num_ff} < pool_ff;
   assign alloc_id   = (cnt_ff != '0) ? top_ff : fresh_ff[ID_W-1:0];
   assign alloc_ok   = (cnt_ff != '0) || (fresh_ff < pool_ff);
   assign release_ok = in_range && used_ff[in_num_ff] && (cnt_ff < idfl_pkg::POOL_MAX);

   always_comb begin
      pool_in = pool_ff;
      if (csr_fire) begin
         priority if (csr_pool_size < idfl_pkg::POOL_MIN) begin
            pool_in = idfl_pkg::POOL_MIN;
         end else if (csr_pool_size > idfl_pkg::POOL_MAX) begin
            pool_in = idfl_pkg::POOL_MAX;
         end else begin
            pool_in = csr_pool_size;
         end
      end
   end

   always_comb begin
      used_in          = used_ff;
      cnt_in           = cnt_ff;
      fresh_in         = fresh_ff;
      top_in           = top_ff;
      byp_valid_in     = 1'b0;
      byp_data_in      = top_ff;
      wr_en            = 1'b0;
      out_granted_in   = 1'b0;
      out_number_in    = '0;
      out_available_in = 1'b0;
      out_released_in  = 1'b0;

      if (csr_fire) begin
         // New pool size: start over with every ID free.
         used_in  = '0;
         cnt_in   = '0;
         fresh_in = '0;
      end else if (advance) begin
         unique case (in_cmd_ff)
            idfl_pkg::CMD_ALLOC: begin
               if (alloc_ok) begin
                  used_in[alloc_id] = 1'b1;
                  out_granted_in    = 1'b1;
                  out_number_in     = alloc_id;
                  if (cnt_ff != '0) begin
                     // Pop: entry below becomes the new top.
                     cnt_in = cnt_dec;
                     top_in = second;
                  end else begin
                     fresh_in = fresh_ff + CNT_W'(1);
                  end
               end
            end
            idfl_pkg::CMD_CHECK: begin
               out_available_in = in_range && !used_ff[in_num_ff];
            end
            idfl_pkg::CMD_RELEASE: begin
               if (release_ok) begin
                  // Push: spill the old top into the RAM, forward it too.
                  used_in[in_num_ff] = 1'b0;
                  out_released_in    = 1'b1;
                  cnt_in             = cnt_ff + CNT_W'(1);
                  top_in             = in_num_ff;
                  wr_en              = (cnt_ff != '0);
                  byp_valid_in       = 1'b1;
               end
            end
            default: begin
               // Unknown command: drop, all result fields zero.
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pool_ff      <= idfl_pkg::POOL_RESET;
         used_ff      <= '0;
         cnt_ff       <= '0;
         fresh_ff     <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pool_ff      <= pool_in;
         used_ff      <= used_in;
         cnt_ff       <= cnt_in;
         fresh_ff     <= fresh_in;
         byp_valid_ff <= byp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      byp_data_ff <= byp_data_in;
      if (accept) begin
         in_cmd_ff <= req_cmd;
         in_num_ff <= req_number;
      end
      if (advance) begin
         out_granted_ff   <= out_granted_in;
         out_number_ff    <= out_number_in;
         out_available_ff <= out_available_in;
         out_released_ff  <= out_released_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_granted    = out_granted_ff;
   assign rsp_number_out = out_number_ff;
   assign rsp_available  = out_available_ff;
   assign rsp_released   = out_released_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= idfl_pkg::POOL_MAX)
      else $error("release stack count above pool limit");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_granted, rsp_available, rsp_released}))
      else $error("more than one result flag set");

   a_grant_marks: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_cmd_ff == idfl_pkg::CMD_ALLOC) && alloc_ok)
      |=> used_ff[$past(alloc_id)])
      else $error("granted ID not marked used");

   a_release_frees: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_cmd_ff == idfl_pkg::CMD_RELEASE) && release_ok)
      |=> (!used_ff[$past(in_num_ff)] && (top_ff == $past(in_num_ff))))
      else $error("released ID not freed or not on stack top");

endmodule

// ===== tb/sv/tb_id_free_list_allocator.sv =====
`timescale 1ns / 100ps

module tb_id_free_list_allocator;

   // Code 3 has no enum member; the block must treat it as a no-op.
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam int LATENCY         = 2;       // input register, then result register
   localparam int CYCLE_LIMIT     = 400000;  // far above the slowest legal run
   localparam int PHASES          = 10;
   localparam int BEATS_PER_PHASE = 180;
   localparam int LONG_HOLD       = 80;      // receiver hold-off, in cycles
   localparam int SHOWN_MISMATCH  = 10;

   typedef struct packed {
      logic       granted;
      logic [7:0] number_out;
      logic       available;
      logic       released;
   } answer_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   cmd;
      logic [7:0]   num;
      bit           fixed;      // expected answer typed into the row
      answer_type   want;
      logic [8:0]   csr_value;
   } row_type;

   // DUT ports; every input starts at a known value.
   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [1:0] req_cmd        = '0;
   logic [7:0] req_number     = '0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_granted;
   logic [7:0] rsp_number_out;
   logic       rsp_available;
   logic       rsp_released;
   logic       csr_valid      = 1'b0;
   logic       csr_ready;
   logic [8:0] csr_pool_size  = '0;

   // Shadow copy of the allocator state.
   logic                       pool_used [idfl_pkg::MAX_IDS];
   logic [idfl_pkg::ID_W-1:0]  free_stack [idfl_pkg::MAX_IDS];
   logic [idfl_pkg::CNT_W-1:0] free_depth;
   logic [idfl_pkg::CNT_W-1:0] next_fresh;
   logic [idfl_pkg::CNT_W-1:0] pool_limit;

   answer_type pending_answers [$];

   // Directed rows may carry a hand-written answer along with the beat.
   bit         beat_fixed = 1'b0;
   answer_type beat_want  = '0;

   row_type directed_rows [$];

   // Idle controls, changed by the stimulus only right after a rising edge.
   int req_gap_pct  = 20;
   int rsp_idle_pct = 20;
   int hold_asks    = 0;
   int holds_done   = 0;
   int hold_left    = 0;
   int stall_left   = 0;
   int run_left     = 0;

   int cycles       = 0;
   int mismatches   = 0;
   int beats_sent   = 0;
   int answers_seen = 0;
   int n_grants     = 0;
   int n_denied     = 0;
   int n_freed      = 0;
   int n_free_hits  = 0;
   int n_csr        = 0;

   id_free_list_allocator i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_granted    (rsp_granted),
      .rsp_number_out (rsp_number_out),
      .rsp_available  (rsp_available),
      .rsp_released   (rsp_released),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_pool_size  (csr_pool_size)
   );

   always #2 clock = ~clock;

   // Start the pool over: everything free, stack empty, fresh count at zero.
   function automatic void pool_clear();
      for (int i = 0; i < idfl_pkg::MAX_IDS; i++) begin
         pool_used[i]  = 1'b0;
         free_stack[i] = '0;
      end
      free_depth = '0;
      next_fresh = '0;
   endfunction

   // Clamp a written size into 1 .. MAX_IDS, then clear the pool.
   function automatic void pool_resize(input logic [8:0] value);
      logic [idfl_pkg::CNT_W-1:0] v;
      v = value;
      if (v < idfl_pkg::POOL_MIN) v = idfl_pkg::POOL_MIN;
      if (v > idfl_pkg::POOL_MAX) v = idfl_pkg::POOL_MAX;
      pool_limit = v;
      pool_clear();
   endfunction

   // Apply one command to the shadow state and return the answer it owes.
   function automatic answer_type pool_answer(input logic [1:0] cmd, input logic [7:0] num);
      answer_type ans;
      logic       in_range;
      ans      = '0;
      in_range = ({1'b0, num} < pool_limit);
      case (cmd)
         idfl_pkg::CMD_ALLOC: begin
            // Reuse the most recent release first, else hand out the next fresh ID.
            if (free_depth != 0) begin
               free_depth             = free_depth - idfl_pkg::CNT_W'(1);
               ans.number_out         = free_stack[free_depth[idfl_pkg::ID_W-1:0]];
               pool_used[ans.number_out] = 1'b1;
               ans.granted            = 1'b1;
            end else if (next_fresh < pool_limit) begin
               ans.number_out         = next_fresh[idfl_pkg::ID_W-1:0];
               pool_used[ans.number_out] = 1'b1;
               ans.granted            = 1'b1;
               next_fresh             = next_fresh + idfl_pkg::CNT_W'(1);
            end
         end
         idfl_pkg::CMD_CHECK: begin
            ans.available = in_range && !pool_used[num];
         end
         idfl_pkg::CMD_RELEASE: begin
            // Drop releases of free or out-of-range IDs.
            if (in_range && pool_used[num] && free_depth < idfl_pkg::POOL_MAX) begin
               pool_used[num]                               = 1'b0;
               free_stack[free_depth[idfl_pkg::ID_W-1:0]]   = num;
               free_depth = free_depth + idfl_pkg::CNT_W'(1);
               ans.released                                 = 1'b1;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic void add_beat(input logic [1:0] cmd, input logic [7:0] num,
                                    input bit fixed, input logic g, input logic [7:0] n,
                                    input logic a, input logic r);
      row_type row;
      row.kind      = ROW_BEAT;
      row.cmd       = cmd;
      row.num       = num;
      row.fixed     = fixed;
      row.want      = '{granted: g, number_out: n, available: a, released: r};
      row.csr_value = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [8:0] value);
      row_type row;
      row.kind      = ROW_CSR;
      row.cmd       = CMD_NONE;
      row.num       = '0;
      row.fixed     = 1'b0;
      row.want      = '0;
      row.csr_value = value;
      directed_rows.push_back(row);
   endfunction

   // Offer one beat at the falling edge, optionally after an idle burst, and hold
   // it until the block takes it. Returns just after the accepting rising edge.
   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] num,
                            input bit fixed, input answer_type want);
      int gap;
      gap = 0;
      if (req_gap_pct > 0 && $urandom_range(0, 99) < req_gap_pct)
         gap = $urandom_range(1, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_number <= num;
      beat_fixed <= fixed;
      beat_want  <= want;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // Drop valid, wait for every owed answer, then let the pipeline settle.
   task automatic drain_answers();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [8:0] value);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_pool_size <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: a long hold-off when asked, else random stall bursts between
   // stall-free runs.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asks != holds_done) begin
         holds_done <= hold_asks;
         hold_left  <= LONG_HOLD - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (run_left > 0) begin
         rsp_stall <= 1'b0;
         run_left  <= run_left - 1;
      end else if (rsp_idle_pct > 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
         run_left  <= $urandom_range(0, 7);
      end
   end

   // Monitor: check the oldest owed answer against every taken rsp beat, then
   // record what each taken req beat owes, then track register writes.
   always @(posedge clock) begin
      answer_type want;
      answer_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{granted: rsp_granted, number_out: rsp_number_out,
                    available: rsp_available, released: rsp_released};
            answers_seen++;
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_MISMATCH)
                  $display("cycle %0d: rsp beat with nothing owed: g=%0d n=%0d a=%0d r=%0d",
                           cycles, got.granted, got.number_out, got.available, got.released);
            end else begin
               want = pending_answers.pop_front();
               if (got.granted !== want.granted || got.number_out !== want.number_out ||
                   got.available !== want.available || got.released !== want.released) begin
                  mismatches++;
                  if (mismatches <= SHOWN_MISMATCH)
                     $display({"cycle %0d: mismatch want g=%0d n=%0d a=%0d r=%0d,",
                               " got g=%0d n=%0d a=%0d r=%0d"},
                              cycles, want.granted, want.number_out, want.available,
                              want.released, got.granted, got.number_out, got.available,
                              got.released);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = pool_answer(req_cmd, req_number);
            if (beat_fixed) want = beat_want;
            if (req_cmd == idfl_pkg::CMD_ALLOC) begin
               if (want.granted) n_grants++;
               else n_denied++;
            end
            if (want.released)  n_freed++;
            if (want.available) n_free_hits++;
            pending_answers.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            pool_resize(csr_pool_size);
            n_csr++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers still owed",
                  cycles, pending_answers.size());
         $display("FAILURE");
         $finish;
      end
   end

   logic [8:0] pool_plan  [PHASES] = '{9'd256, 9'd1, 9'd2, 9'd0, 9'd300,
                                       9'd17, 9'd255, 9'd128, 9'd511, 9'd20};
   int         gap_plan   [PHASES] = '{25, 30, 0, 40, 20, 25, 10, 35, 0, 0};
   int         stall_plan [PHASES] = '{25, 20, 0, 30, 40, 25, 10, 35, 0, 0};

   initial begin
      int         p;
      int         k;
      int         pct;
      int         r;
      int         start;
      bit         found;
      logic [1:0] c;
      logic [7:0] nb;

      pool_resize(idfl_pkg::POOL_RESET);

      // Hold reset, then release it on a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: reset pool, reuse order, no-op code, tiny pool, clamps.
      add_beat(idfl_pkg::CMD_CHECK,   8'd0,   1, 0, 8'd0, 1, 0);
      add_beat(idfl_pkg::CMD_CHECK,   8'd255, 1, 0, 8'd0, 1, 0);
      add_beat(idfl_pkg::CMD_RELEASE, 8'd0,   1, 0, 8'd0, 0, 0);   // free ID: ignore
      add_beat(CMD_NONE,              8'd255, 1, 0, 8'd0, 0, 0);
      add_beat(idfl_pkg::CMD_ALLOC,   8'd255, 1, 1, 8'd0, 0, 0);
      add_beat(idfl_pkg::CMD_ALLOC,   8'd0,   1, 1, 8'd1, 0, 0);
      add_beat(idfl_pkg::CMD_CHECK,   8'd0,   1, 0, 8'd0, 0, 0);
      add_beat(idfl_pkg::CMD_RELEASE, 8'd0,   1, 0, 8'd0, 0, 1);
      add_beat(idfl_pkg::CMD_RELEASE, 8'd0,   1, 0, 8'd0, 0, 0);   // double release
      add_beat(idfl_pkg::CMD_RELEASE, 8'd1,   1, 0, 8'd0, 0, 1);
      add_beat(idfl_pkg::CMD_ALLOC,   8'd0,   1, 1, 8'd1, 0, 0);   // last freed first
      add_beat(idfl_pkg::CMD_ALLOC,   8'd0,   1, 1, 8'd0, 0, 0);
      add_beat(idfl_pkg::CMD_ALLOC,   8'd0,   1, 1, 8'd2, 0, 0);
      add_beat(CMD_NONE,              8'd0,   1, 0, 8'd0, 0, 0);
      add_csr(9'd0);                                                // taken as one
      add_beat(idfl_pkg::CMD_CHECK,   8'd0,   1, 0, 8'd0, 1, 0);
      add_beat(idfl_pkg::CMD_CHECK,   8'd1,   1, 0, 8'd0, 0, 0);   // out of range
      add_beat(idfl_pkg::CMD_ALLOC,   8'd0,   1, 1, 8'd0, 0, 0);
      add_beat(idfl_pkg::CMD_ALLOC,   8'd0,   1, 0, 8'd0, 0, 0);   // pool exhausted
      add_beat(idfl_pkg::CMD_RELEASE, 8'd255, 1, 0, 8'd0, 0, 0);   // out of range
      add_beat(idfl_pkg::CMD_RELEASE, 8'd0,   1, 0, 8'd0, 0, 1);
      add_beat(idfl_pkg::CMD_ALLOC,   8'd0,   1, 1, 8'd0, 0, 0);
      add_beat(idfl_pkg::CMD_ALLOC,   8'd0,   1, 0, 8'd0, 0, 0);
      add_csr(9'd511);                                              // clamped to the maximum
      add_beat(idfl_pkg::CMD_CHECK,   8'd0,   1, 0, 8'd0, 1, 0);   // map cleared by the write
      add_beat(idfl_pkg::CMD_CHECK,   8'd255, 1, 0, 8'd0, 1, 0);
      add_beat(idfl_pkg::CMD_ALLOC,   8'd170, 1, 1, 8'd0, 0, 0);   // fresh count restarted
      add_beat(idfl_pkg::CMD_ALLOC,   8'd85,  0, 0, 8'd0, 0, 0);
      add_beat(idfl_pkg::CMD_RELEASE, 8'd1,   0, 0, 8'd0, 0, 0);
      add_beat(idfl_pkg::CMD_CHECK,   8'd1,   0, 0, 8'd0, 0, 0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_answers();
            csr_write(directed_rows[i].csr_value);
         end else begin
            send_beat(directed_rows[i].cmd, directed_rows[i].num,
                      directed_rows[i].fixed, directed_rows[i].want);
         end
      end

      // Random part: one pool size per phase. The first half of each phase leans
      // on allocate to exhaust the pool, the second half on release to fill the
      // stack; most releases name an ID that is really held.
      pool_plan[7] = 9'($urandom_range(1, 256));
      pool_plan[9] = 9'($urandom_range(3, 40));
      for (p = 0; p < PHASES; p++) begin
         drain_answers();
         req_gap_pct  = gap_plan[p];
         rsp_idle_pct = stall_plan[p];
         csr_write(pool_plan[p]);
         for (k = 0; k < BEATS_PER_PHASE; k++) begin
            pct = (k < BEATS_PER_PHASE / 2) ? 70 : 30;
            r   = $urandom_range(0, 99);
            nb  = 8'($urandom_range(0, 255));
            if (r < pct) begin
               c = idfl_pkg::CMD_ALLOC;
            end else if (r < 88) begin
               c     = idfl_pkg::CMD_RELEASE;
               found = 1'b0;
               start = $urandom_range(0, pool_limit - 1);
               for (int j = 0; j < pool_limit && !found; j++) begin
                  if (pool_used[(start + j) % pool_limit]) begin
                     nb    = 8'((start + j) % pool_limit);
                     found = 1'b1;
                  end
               end
            end else if (r < 95) begin
               c = idfl_pkg::CMD_CHECK;
            end else if (r < 98) begin
               c = idfl_pkg::CMD_RELEASE;
            end else begin
               c = CMD_NONE;
            end
            send_beat(c, nb, 1'b0, '0);
            // Hold off the receiver long enough to back the block up into req.
            if (p == 3 && k == 40) hold_asks++;
            // Pause the sender until every owed answer is in.
            if (p == 5 && k == 90) drain_answers();
         end
      end

      drain_answers();
      repeat (8) @(posedge clock);

      $display("covered %0d beats over %0d pool size writes, %0d answers checked",
               beats_sent, n_csr, answers_seen);
      $display("grants %0d, pool-empty denials %0d, releases %0d, free checks %0d",
               n_grants, n_denied, n_freed, n_free_hits);
      $display("mismatches %0d", mismatches);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
